>>> hdl/blifo_pkg.sv
// ---------------------------------------------------------------------------
// blifo_pkg
// Shared field widths, operation codes, register indexes and reset values of
// the bounded lifo with min search.
// ---------------------------------------------------------------------------
`default_nettype none

package blifo_pkg;

   localparam int TAG_W  = 16;
   localparam int DATE_W = 20;
   localparam int MODE_W = 2;
   localparam int CFG_W  = 5;
   localparam int APB_W  = 32;
   localparam int ADDR_W = 3;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_PUSH = 2'd0;
   localparam mode_type MODE_POP  = 2'd1;
   localparam mode_type MODE_FIND = 2'd2;
   localparam mode_type MODE_NOP  = 2'd3;

   localparam logic REG_STACK_COUNT    = 1'b0;
   localparam logic REG_STACK_CAPACITY = 1'b1;

   localparam logic [CFG_W-1:0] STACK_COUNT_RESET    = 5'd2;
   localparam logic [CFG_W-1:0] STACK_CAPACITY_RESET = 5'd1;

endpackage

`default_nettype wire

>>> hdl/bounded_lifo_with_min_search.sv
// latency: push, unknown op, pop or find on an empty store: result strobe in the
//   cycle after the accept, and a new beat may be started in that same cycle
// pop: result follows the registered memory read and then the pop state
// find: result follows a scan of the stored entries, one entry per cycle through
//   the single read port of the entry memory, and the compare stage; busy stays high meanwhile
// reset: synchronous, empties the store and restores the register defaults
// ---------------------------------------------------------------------------
// bounded_lifo_with_min_search
// Lifo of tagged entries, split into stacks of configurable capacity, with
// push, pop and a sequential scan for the earliest date.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_with_min_search
   import blifo_pkg::*;
#(
   parameter int MAX_ENTRIES     = 256,
   parameter int MAX_STACK_DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic [MODE_W-1:0]                     req_mode,
   input  wire logic [TAG_W-1:0]                      req_name_tag,
   input  wire logic [DATE_W-1:0]                     req_expiry_date,
   output      logic                                  rsp_strobe,
   output      logic                                  rsp_accepted,
   output      logic                                  rsp_found,
   output      logic [TAG_W-1:0]                      rsp_out_name_tag,
   output      logic [DATE_W-1:0]                     rsp_out_expiry_date,
   output      logic [$clog2(MAX_ENTRIES+1)-1:0]      rsp_entry_count,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [ADDR_W-1:0]                     paddr,
   input  wire logic [APB_W-1:0]                      pwdata,
   output      logic [APB_W-1:0]                      prdata,
   output      logic                                  pready
);

   localparam int CNT_W = $clog2(MAX_ENTRIES+1);
   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int PRD_W = 2*CFG_W;
   localparam int LIM_W = (CNT_W > PRD_W) ? CNT_W : PRD_W;
   localparam int SW    = LIM_W + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_POP   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CFG_W-1:0]  count_cfg_ff, count_cfg_in;
   logic [CFG_W-1:0]  cap_cfg_ff, cap_cfg_in;
   logic [SW-1:0]     base_ff, base_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_last_ff, rd_last_in;
   logic              best_vld_ff, best_vld_in;
   logic [TAG_W-1:0]  best_tag_ff, best_tag_in;
   logic [DATE_W-1:0] best_date_ff, best_date_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic              rsp_fnd_ff, rsp_fnd_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [DATE_W-1:0] rsp_date_ff, rsp_date_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic [TAG_W-1:0]  tag_mem [MAX_ENTRIES];
   logic [DATE_W-1:0] date_mem [MAX_ENTRIES];
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [DATE_W-1:0] rd_date_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;

   logic              accept;
   logic              csr_wr;
   logic [CFG_W-1:0]  count_eff;
   logic [CFG_W-1:0]  cap_eff;
   logic [PRD_W-1:0]  prod;
   logic [LIM_W-1:0]  limit;
   logic              full;
   logic [SW-1:0]     fill_sw;
   logic [SW-1:0]     cap_sw;
   logic [SW-1:0]     end0;
   logic [SW-1:0]     next_base;
   logic [SW-1:0]     next_end;
   logic              stack_end;
   logic              scan_done;
   logic              cand_better;
   logic [TAG_W-1:0]  sel_tag;
   logic [DATE_W-1:0] sel_date;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_STACK_COUNT) begin
         prdata[CFG_W-1:0] = count_cfg_ff;
      end else begin
         prdata[CFG_W-1:0] = cap_cfg_ff;
      end
   end

   // effective geometry
   always_comb begin
      count_eff = (count_cfg_ff < 5'd2) ? 5'd2 : count_cfg_ff;
      if (cap_cfg_ff == '0) begin
         cap_eff = 5'd1;
      end else if (32'(cap_cfg_ff) > MAX_STACK_DEPTH) begin
         cap_eff = CFG_W'(MAX_STACK_DEPTH);
      end else begin
         cap_eff = cap_cfg_ff;
      end
      prod = PRD_W'(count_eff - 5'd1) * PRD_W'(cap_eff);
      if (32'(prod) > MAX_ENTRIES) begin
         limit = LIM_W'(MAX_ENTRIES);
      end else begin
         limit = LIM_W'(prod);
      end
      full    = LIM_W'(fill_ff) >= limit;
      fill_sw = SW'(fill_ff);
      cap_sw  = SW'(cap_eff);
      end0    = (cap_sw > fill_sw) ? fill_sw : cap_sw;
   end

   // scan address walk: stacks oldest first, each from its top down
   always_comb begin
      stack_end = (SW'(idx_ff) == base_ff);
      next_base = base_ff + cap_sw;
      scan_done = (next_base >= fill_sw);
      next_end  = next_base + cap_sw;
      if (next_end > fill_sw) begin
         next_end = fill_sw;
      end
   end

   always_comb begin
      cand_better = !best_vld_ff || (rd_date_ff < best_date_ff);
      sel_tag     = cand_better ? rd_tag_ff : best_tag_ff;
      sel_date    = cand_better ? rd_date_ff : best_date_ff;
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      count_cfg_in  = count_cfg_ff;
      cap_cfg_in    = cap_cfg_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = 1'b0;
      best_vld_in   = best_vld_ff;
      best_tag_in   = best_tag_ff;
      best_date_in  = best_date_ff;
      rsp_strobe_in = 1'b0;
      rsp_acc_in    = rsp_acc_ff;
      rsp_fnd_in    = rsp_fnd_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_date_in   = rsp_date_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(fill_ff);
      mem_raddr     = idx_ff;

      if (csr_wr) begin
         if (paddr[2] == REG_STACK_COUNT) begin
            count_cfg_in = pwdata[CFG_W-1:0];
         end else begin
            cap_cfg_in = pwdata[CFG_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = AW'(fill_ff - CNT_W'(1));
            if (accept) begin
               rsp_acc_in  = 1'b0;
               rsp_fnd_in  = 1'b0;
               rsp_tag_in  = '0;
               rsp_date_in = '0;
               rsp_cnt_in  = fill_ff;
               unique case (req_mode)
                  MODE_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (!full) begin
                        mem_we     = 1'b1;
                        fill_in    = fill_ff + CNT_W'(1);
                        rsp_acc_in = 1'b1;
                        rsp_cnt_in = fill_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP: begin
                     if (fill_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        fill_in  = fill_ff - CNT_W'(1);
                        state_in = ST_POP;
                     end
                  end
                  MODE_FIND: begin
                     if (fill_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        base_in     = '0;
                        idx_in      = AW'(end0 - SW'(1));
                        best_vld_in = 1'b0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_strobe_in = 1'b1;
            rsp_fnd_in    = 1'b1;
            rsp_tag_in    = rd_tag_ff;
            rsp_date_in   = rd_date_ff;
            rsp_cnt_in    = fill_ff;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (stack_end) begin
               if (scan_done) begin
                  rd_last_in = 1'b1;
                  state_in   = ST_DRAIN;
               end else begin
                  base_in = next_base;
                  idx_in  = AW'(next_end - SW'(1));
               end
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // compare stage, fed by the registered read
      if (rd_vld_ff) begin
         best_vld_in  = 1'b1;
         best_tag_in  = sel_tag;
         best_date_in = sel_date;
         if (rd_last_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_fnd_in    = 1'b1;
            rsp_tag_in    = sel_tag;
            rsp_date_in   = sel_date;
            rsp_cnt_in    = fill_ff;
            state_in      = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         count_cfg_ff  <= STACK_COUNT_RESET;
         cap_cfg_ff    <= STACK_CAPACITY_RESET;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         best_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         count_cfg_ff  <= count_cfg_in;
         cap_cfg_ff    <= cap_cfg_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         best_vld_ff   <= best_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      best_tag_ff  <= best_tag_in;
      best_date_ff <= best_date_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_fnd_ff   <= rsp_fnd_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_date_ff  <= rsp_date_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr]  <= req_name_tag;
         date_mem[mem_waddr] <= req_expiry_date;
      end
      rd_tag_ff  <= tag_mem[mem_raddr];
      rd_date_ff <= date_mem[mem_raddr];
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_found           = rsp_fnd_ff;
   assign rsp_out_name_tag    = rsp_tag_ff;
   assign rsp_out_expiry_date = rsp_date_ff;
   assign rsp_entry_count     = rsp_cnt_ff;

endmodule

`default_nettype wire

>>> hdl/blifo_checker.sv
// ---------------------------------------------------------------------------
// blifo_checker
// Port-level checks of the bounded lifo with min search, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module blifo_checker
   import blifo_pkg::*;
#(
   parameter int CNT_W = 9
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire logic              rsp_accepted,
   input wire logic              rsp_found,
   input wire logic [TAG_W-1:0]  rsp_out_name_tag,
   input wire logic [DATE_W-1:0] rsp_out_expiry_date,
   input wire logic [CNT_W-1:0]  rsp_entry_count
);

   // an accepted beat is followed either by its answer or by the block held busy
   a_accept_answer : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted beat neither answered nor held busy");

   a_acc_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_accepted |-> !rsp_found)
      else $error("push beat reports found");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_out_name_tag == '0 && rsp_out_expiry_date == '0)
      else $error("result without entry carries nonzero payload");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_accepted |-> rsp_entry_count != '0)
      else $error("stored push reports an empty store");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind bounded_lifo_with_min_search blifo_checker #(
   .CNT_W($clog2(MAX_ENTRIES+1))
) u_blifo_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_accepted        (rsp_accepted),
   .rsp_found           (rsp_found),
   .rsp_out_name_tag    (rsp_out_name_tag),
   .rsp_out_expiry_date (rsp_out_expiry_date),
   .rsp_entry_count     (rsp_entry_count)
);

`default_nettype wire
